>>> rtl/int_axis_reduce_unit_defines.svh
// assertion helpers shared by the reduce unit
`ifndef INT_AXIS_REDUCE_UNIT_DEFINES_SVH
`define INT_AXIS_REDUCE_UNIT_DEFINES_SVH

// checked only outside reset
`define IAR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define IAR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/iar_pkg.sv
// ----------------------------------------------------------------------------
// iar_pkg
// shared types and constants of the axis reduce unit
// ----------------------------------------------------------------------------
package iar_pkg;

   localparam int INNER_MAX_DEF = 1024;
   localparam int AXIS_MAX_DEF  = 65536;

   localparam int DATA_W  = 32;
   localparam int MODE_W  = 3;
   localparam int INNER_W = 11;
   localparam int AXIS_W  = 17;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [MODE_W-1:0] MODE_SUM  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MEAN = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MAX  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MIN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PROD = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ALL  = 3'd5;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_INNER = 2'd1;
   localparam logic [1:0] REG_AXIS  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic capture;
      logic exec;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_row;
      logic mean;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

>>> rtl/iar_ram.sv
// ----------------------------------------------------------------------------
// iar_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module iar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/iar_ctrl.sv
// ----------------------------------------------------------------------------
// iar_ctrl
// sequencer: read, execute, optional divide, optional output load
// ----------------------------------------------------------------------------
module iar_ctrl import iar_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (!status.last_row) state_in = ST_IDLE;
            else if (status.mean) state_in = ST_DIV;
            else                  state_in = ST_OUT;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_READ: cmd.capture  = 1'b1;
         ST_EXEC: cmd.exec     = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_OUT:  cmd.out_load = status.out_free;
         default: req_stall    = 1'b1;
      endcase
   end

endmodule

>>> rtl/iar_dp.sv
// ----------------------------------------------------------------------------
// iar_dp
// counters, accumulator ram, fold unit, serial divider and output register
// ----------------------------------------------------------------------------
module iar_dp import iar_pkg::*; #(
   parameter int INNER_MAX = INNER_MAX_DEF,
   parameter int AXIS_MAX  = AXIS_MAX_DEF,
   localparam int COL_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1,
   localparam int ROW_W = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cfg_clear,
   input  logic [MODE_W-1:0]        mode,
   input  logic [INNER_W-1:0]       inner,
   input  logic [AXIS_W-1:0]        axis,
   input  logic signed [DATA_W-1:0] req_elem_value,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [COL_W-1:0]         rsp_column_index,
   output logic                     rsp_overflow_flag,
   output logic                     rsp_group_last
);

   localparam int QCNT_W = $clog2(DATA_W);

   logic [COL_W-1:0]        col_ff, cur_col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [DATA_W-1:0]       x_ff, a_ff, res_ff;
   logic                    a_ovf_ff, res_ovf_ff;
   logic                    first_ff, last_ff, glast_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic [DATA_W-1:0]       dq_ff;
   logic [AXIS_W:0]         rem_ff;
   logic [QCNT_W-1:0]       dcnt_ff;
   logic                    neg_ff;
   logic                    out_valid_ff, out_ovf_ff, out_glast_ff;
   logic [DATA_W-1:0]       out_val_ff;
   logic [COL_W-1:0]        out_col_ff;

   logic                    col_wrap, row_wrap;
   logic [DATA_W:0]         rd_word;
   logic [DATA_W-1:0]       acc;
   logic                    acc_ovf, prod_ovf;
   logic [AXIS_W:0]         rem_sh, rem_sub;
   logic                    q_bit;
   logic [DATA_W-1:0]       quot;

   assign col_wrap = (32'(col_ff) + 32'd1) >= 32'(inner);
   assign row_wrap = (32'(row_ff) + 32'd1) >= 32'(axis);

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.accept) begin
         col_ff <= col_wrap ? '0 : col_ff + 1'b1;
         if (col_wrap) row_ff <= row_wrap ? '0 : row_ff + 1'b1;
      end
   end

   iar_ram #(.WIDTH(DATA_W + 1), .DEPTH(INNER_MAX)) u_acc_ram (
      .clock   (clock),
      .wr_en   (cmd.exec),
      .wr_addr (cur_col_ff),
      .wr_data ({acc_ovf, acc}),
      .rd_en   (cmd.accept),
      .rd_addr (col_ff),
      .rd_data (rd_word)
   );

   // capture the item and where it sits in the group, then the ram word and product
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff       <= req_elem_value;
         cur_col_ff <= col_ff;
         first_ff   <= (row_ff == '0);
         last_ff    <= row_wrap;
         glast_ff   <= col_wrap;
      end
      if (cmd.capture) begin
         a_ff     <= rd_word[DATA_W-1:0];
         a_ovf_ff <= rd_word[DATA_W];
         prod_ff  <= $signed(rd_word[DATA_W-1:0]) * $signed(x_ff);
      end
   end

   assign prod_ovf = !((&prod_ff[2*DATA_W-1:DATA_W-1]) || !(|prod_ff[2*DATA_W-1:DATA_W-1]));

   always_comb begin
      acc     = a_ff + x_ff;
      acc_ovf = a_ovf_ff;
      if (first_ff) begin
         acc     = (mode == MODE_ALL) ? DATA_W'(x_ff != '0) : x_ff;
         acc_ovf = 1'b0;
      end else begin
         case (mode)
            MODE_MAX: acc = ($signed(x_ff) > $signed(a_ff)) ? x_ff : a_ff;
            MODE_MIN: acc = ($signed(x_ff) < $signed(a_ff)) ? x_ff : a_ff;
            MODE_PROD: begin
               acc     = prod_ff[DATA_W-1:0];
               acc_ovf = a_ovf_ff | prod_ovf;
            end
            MODE_ALL: acc = DATA_W'((a_ff != '0) && (x_ff != '0));
            default:  acc = a_ff + x_ff;
         endcase
      end
   end

   // restoring divide of the magnitude, one quotient bit per cycle
   assign rem_sh  = {rem_ff[AXIS_W-1:0], dq_ff[DATA_W-1]};
   assign q_bit   = rem_sh >= {1'b0, axis};
   assign rem_sub = rem_sh - {1'b0, axis};
   assign quot    = neg_ff ? (~dq_ff + 1'b1) : dq_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_ff     <= acc;
         res_ovf_ff <= acc_ovf;
         neg_ff     <= acc[DATA_W-1];
         dq_ff      <= acc[DATA_W-1] ? (~acc + 1'b1) : acc;
         rem_ff     <= '0;
         dcnt_ff    <= '1;
      end else if (cmd.div_step) begin
         dq_ff   <= {dq_ff[DATA_W-2:0], q_bit};
         rem_ff  <= q_bit ? rem_sub : rem_sh;
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_val_ff   <= (mode == MODE_MEAN) ? quot : res_ff;
         out_col_ff   <= cur_col_ff;
         out_ovf_ff   <= (mode == MODE_PROD) && res_ovf_ff;
         out_glast_ff <= glast_ff;
      end
   end

   assign status.last_row = last_ff;
   assign status.mean     = (mode == MODE_MEAN);
   assign status.div_last = (dcnt_ff == '0);
   assign status.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_value  = out_val_ff;
   assign rsp_column_index  = out_col_ff;
   assign rsp_overflow_flag = out_ovf_ff;
   assign rsp_group_last    = out_glast_ff;

endmodule

>>> rtl/int_axis_reduce_unit.sv
// ----------------------------------------------------------------------------
// int_axis_reduce_unit
// streaming sum / mean / max / min / product / all reduction along one axis
// ----------------------------------------------------------------------------
// usage
//   req channel: one signed 32-bit element per beat, tensor memory order
//   rsp channel: one result beat per element of the last axis row of a group
//   csr port: apb-style, mode at 0x0, inner_count at 0x4, axis_count at 0x8;
//     any write to those three registers restarts the group, writes only while the block is idle
// timing
//   one element at a time; req_stall is low only in the idle state
//   an element goes through ram read, ram capture with the 32x32 multiply, fold and
//   ram write-back; a last-row element then loads the output register, in mean
//   mode only after the bit-serial divider has run
// reset
//   synchronous; counters cleared, mode sum, both counts 1; the ram needs
//   no clearing since the first row of every group loads it
// backpressure
//   a stalled result sits in the output register; elements that give no
//   result are still taken, but the next result-producing element waits at
//   its output load and holds req_stall high until the waiting beat is taken
// ----------------------------------------------------------------------------
`include "int_axis_reduce_unit_defines.svh"

module int_axis_reduce_unit import iar_pkg::*; #(
   parameter int INNER_MAX = INNER_MAX_DEF,
   parameter int AXIS_MAX  = AXIS_MAX_DEF,
   localparam int COL_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   // element input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_elem_value,
   // result output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [COL_W-1:0]         rsp_column_index,
   output logic                     rsp_overflow_flag,
   output logic                     rsp_group_last,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready
);

   logic [MODE_W-1:0]  mode_ff;
   logic [INNER_W-1:0] inner_ff;
   logic [AXIS_W-1:0]  axis_ff;
   logic               csr_wr, cfg_clear;
   logic [1:0]         csr_idx;
   logic [INNER_W-1:0] inner_raw, inner_in;
   logic [AXIS_W-1:0]  axis_raw, axis_in;
   cmd_type            cmd;
   status_type         status;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite;

   // counts clamp into [1, max]
   assign inner_raw = pwdata[INNER_W-1:0];
   assign axis_raw  = pwdata[AXIS_W-1:0];
   assign inner_in  = (inner_raw == '0) ? INNER_W'(1) :
                      (32'(inner_raw) > 32'(INNER_MAX)) ? INNER_W'(INNER_MAX) : inner_raw;
   assign axis_in   = (axis_raw == '0) ? AXIS_W'(1) :
                      (32'(axis_raw) > 32'(AXIS_MAX)) ? AXIS_W'(AXIS_MAX) : axis_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SUM;
         inner_ff <= INNER_W'(1);
         axis_ff  <= AXIS_W'(1);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MODE:  mode_ff  <= pwdata[MODE_W-1:0];
            REG_INNER: inner_ff <= inner_in;
            REG_AXIS:  axis_ff  <= axis_in;
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   // any write to a real register restarts the group
   assign cfg_clear = csr_wr && (csr_idx == REG_MODE || csr_idx == REG_INNER ||
                                 csr_idx == REG_AXIS);

   always_comb begin
      case (csr_idx)
         REG_MODE:  prdata = CSR_DW'(mode_ff);
         REG_INNER: prdata = CSR_DW'(inner_ff);
         REG_AXIS:  prdata = CSR_DW'(axis_ff);
         default:   prdata = '0;
      endcase
   end

   iar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   iar_dp #(.INNER_MAX(INNER_MAX), .AXIS_MAX(AXIS_MAX)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg_clear         (cfg_clear),
      .mode              (mode_ff),
      .inner             (inner_ff),
      .axis              (axis_ff),
      .req_elem_value    (req_elem_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_column_index  (rsp_column_index),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_group_last    (rsp_group_last)
   );

   // one element in flight: an accepted beat blocks the next cycle
   `IAR_ASSERT(a_one_in_flight, (req_valid && !req_stall) |=> req_stall, "second element taken while busy")
   // overflow is reported only in product mode
   `IAR_ASSERT(a_ovf_prod_only, rsp_valid && rsp_overflow_flag |-> mode_ff == MODE_PROD, "overflow outside product mode")
   // group end lines up with the last column
   `IAR_ASSERT(a_glast_col, rsp_valid && rsp_group_last |-> 32'(rsp_column_index) + 32'd1 == 32'(inner_ff), "group end on wrong column")
   // output load never drops a waiting result
   `IAR_ASSERT_ALWAYS(a_no_overwrite, !(cmd.out_load && rsp_valid && rsp_stall), "result overwritten")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the streaming axis reduce unit
// ----------------------------------------------------------------------------
// a table of directed beats runs first, then random phases that each program
// mode, inner_count and axis_count and stream whole groups with random
// content, sometimes cut short mid-group. every accepted element is folded
// into a local column model that queues the expected result beat. the
// result monitor compares each rsp beat field by field with the oldest
// queued beat. both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import iar_pkg::*;

   localparam int COLS        = 1024;
   localparam int SETTLE      = 48;    // covers the mean divider latency
   localparam int WATCH_LIMIT = 4000;
   localparam int ITEM_GOAL   = 1450;
   localparam int DIR_ROWS    = 25;

   typedef struct {
      logic [DATA_W-1:0] value;
      logic [9:0]        column;
      logic              ovf;
      logic              last;
   } col_result_type;

   typedef struct {
      bit                cfg;
      logic [2:0]        mode;
      int unsigned       inner;
      int unsigned       axis;
      logic [DATA_W-1:0] elem;
      bit                chk;
      logic [DATA_W-1:0] val;
      bit                ovf;
   } dir_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_elem_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [9:0]               rsp_column_index;
   logic                     rsp_overflow_flag;
   logic                     rsp_group_last;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_AW-1:0]        paddr;
   logic [CSR_DW-1:0]        pwdata;
   logic [CSR_DW-1:0]        prdata;
   logic                     pready;

   // column model state
   logic [DATA_W-1:0] col_acc [COLS];
   bit                col_ovf [COLS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [2:0]        cur_mode;
   int unsigned       cur_inner;
   int unsigned       cur_axis;

   col_result_type pending_results[$];
   int          errors;
   int          idle_cycles;
   int          elems_sent;
   bit          calm;          // stretch with no idling on either side
   dir_row_type dir_tab [0:DIR_ROWS-1];

   int_axis_reduce_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_elem_value    (req_elem_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_column_index  (rsp_column_index),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_group_last    (rsp_group_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned draw_gap();
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   // fold one element into its column and queue the result beat it causes
   function automatic void fold_element(logic [DATA_W-1:0] x);
      logic [DATA_W-1:0] prev;
      logic [DATA_W-1:0] acc;
      bit                ov;
      longint            prod;
      longint            quot;
      col_result_type    r;
      if (cur_row == 0) begin
         acc = (cur_mode == MODE_ALL) ? DATA_W'(x != 0) : x;
         ov  = 1'b0;
      end else begin
         prev = col_acc[cur_col];
         ov   = col_ovf[cur_col];
         case (cur_mode)
            MODE_MAX: acc = ($signed(x) > $signed(prev)) ? x : prev;
            MODE_MIN: acc = ($signed(x) < $signed(prev)) ? x : prev;
            MODE_PROD: begin
               prod = longint'($signed(prev)) * longint'($signed(x));
               if (prod > 64'sd2147483647 || prod < -64'sd2147483648) ov = 1'b1;
               acc = prod[31:0];
            end
            MODE_ALL: acc = DATA_W'(prev != 0 && x != 0);
            default:  acc = prev + x;   // sum, mean and the unused codes
         endcase
      end
      col_acc[cur_col] = acc;
      col_ovf[cur_col] = ov;
      if (cur_row + 1 >= cur_axis) begin
         r.value = acc;
         if (cur_mode == MODE_MEAN) begin
            // signed division truncates toward zero
            quot    = longint'($signed(acc)) / longint'(cur_axis);
            r.value = quot[31:0];
         end
         r.column = cur_col[9:0];
         r.ovf    = (cur_mode == MODE_PROD) ? ov : 1'b0;
         r.last   = (cur_col + 1 >= cur_inner);
         pending_results.push_back(r);
      end
      cur_col++;
      if (cur_col >= cur_inner) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= cur_axis) cur_row = 0;
      end
   endfunction

   task automatic send_element(logic [DATA_W-1:0] x);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_elem_value <= x;
      do @(posedge clock); while (!(req_valid && !req_stall));
      fold_element(x);
      elems_sent++;
   endtask

   // wait until every result has arrived and the unit has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CSR_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_MODE:  cur_mode  = data[2:0];
         REG_INNER: cur_inner = clamp_count(data[10:0], COLS);
         default:   cur_axis  = clamp_count(data[16:0], AXIS_MAX_DEF);
      endcase
      // any write restarts the group
      cur_col = 0;
      cur_row = 0;
   endtask

   task automatic set_config(logic [2:0] mode, int unsigned inner, int unsigned axis);
      drain();
      write_reg(REG_MODE, CSR_DW'(mode));
      write_reg(REG_INNER, inner);
      write_reg(REG_AXIS, axis);
   endtask

   function automatic logic [DATA_W-1:0] rand_elem();
      case ($urandom_range(0, 5))
         0:       return DATA_W'($urandom_range(0, 8)) - 32'd4;
         1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         2:       return DATA_W'($urandom_range(0, 2000)) - 32'd1000;
         3:       return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   // result side: random stall before each beat, sometimes none at all
   initial begin
      int unsigned n;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = draw_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // result monitor
   always @(posedge clock) begin
      col_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat value %h column %0d", $time,
                     rsp_result_value, rsp_column_index);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_value !== e.value) begin
               $display("%0t: result_value expected %h actual %h", $time, e.value,
                        rsp_result_value);
               errors++;
            end
            if (rsp_column_index !== e.column) begin
               $display("%0t: column_index expected %0d actual %0d", $time, e.column,
                        rsp_column_index);
               errors++;
            end
            if (rsp_overflow_flag !== e.ovf) begin
               $display("%0t: overflow_flag expected %b actual %b", $time, e.ovf,
                        rsp_overflow_flag);
               errors++;
            end
            if (rsp_group_last !== e.last) begin
               $display("%0t: group_last expected %b actual %b", $time, e.last,
                        rsp_group_last);
               errors++;
            end
         end
      end
   end

   // watchdog: no beat and no register access for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [2:0]  mode;
      int unsigned inner;
      int unsigned axis;
      int unsigned count;
      int unsigned phase;
      req_valid      = 1'b0;
      req_elem_value = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      reset          = 1'b1;
      errors         = 0;
      idle_cycles    = 0;
      elems_sent     = 0;
      calm           = 1'b0;
      cur_mode       = MODE_SUM;
      cur_inner      = 1;
      cur_axis       = 1;
      cur_col        = 0;
      cur_row        = 0;

      // cfg, mode, inner, axis, element, typed check, value, overflow
      dir_tab = '{
         // reset state: sum with both counts 1
         '{0, MODE_SUM,  0, 0, 32'h7fff_ffff, 1, 32'h7fff_ffff, 0},
         '{0, MODE_SUM,  0, 0, 32'h8000_0000, 1, 32'h8000_0000, 0},
         // max starts from the first element, so int_min survives
         '{1, MODE_MAX,  1, 2, 32'h8000_0000, 0, 32'h0, 0},
         '{0, MODE_MAX,  0, 0, 32'h8000_0000, 1, 32'h8000_0000, 0},
         '{1, MODE_MIN,  1, 2, 32'h7fff_ffff, 0, 32'h0, 0},
         '{0, MODE_MIN,  0, 0, 32'h7fff_ffff, 1, 32'h7fff_ffff, 0},
         // product overflow wraps and sets the flag
         '{1, MODE_PROD, 1, 2, 32'h0001_0000, 0, 32'h0, 0},
         '{0, MODE_PROD, 0, 0, 32'h0001_0000, 1, 32'h0, 1},
         '{1, MODE_ALL,  1, 2, 32'h0000_0005, 0, 32'h0, 0},
         '{0, MODE_ALL,  0, 0, 32'h0000_0000, 1, 32'h0, 0},
         // mean truncates toward zero
         '{1, MODE_MEAN, 1, 2, 32'hffff_fffd, 0, 32'h0, 0},
         '{0, MODE_MEAN, 0, 0, 32'h0000_0000, 1, 32'hffff_ffff, 0},
         // unused mode codes act as sum
         '{1, 3'd7,      1, 2, 32'hffff_ffff, 0, 32'h0, 0},
         '{0, 3'd7,      0, 0, 32'h0000_0001, 1, 32'h0, 0},
         // zero counts act as 1
         '{1, 3'd6,      0, 0, 32'h0000_002a, 1, 32'h0000_002a, 0},
         '{1, MODE_MEAN, 3, 2, 32'h0000_000a, 0, 32'h0, 0},
         '{0, MODE_MEAN, 0, 0, 32'hffff_fff9, 0, 32'h0, 0},
         '{0, MODE_MEAN, 0, 0, 32'h0000_0005, 0, 32'h0, 0},
         '{0, MODE_MEAN, 0, 0, 32'h0000_0001, 0, 32'h0, 0},
         '{0, MODE_MEAN, 0, 0, 32'h8000_0000, 0, 32'h0, 0},
         '{0, MODE_MEAN, 0, 0, 32'h7fff_ffff, 0, 32'h0, 0},
         // partial group, abandoned by the next write
         '{1, MODE_MAX,  2, 3, 32'h8000_0000, 0, 32'h0, 0},
         '{0, MODE_MAX,  0, 0, 32'hffff_ffff, 0, 32'h0, 0},
         '{0, MODE_MAX,  0, 0, 32'h8000_0000, 0, 32'h0, 0},
         '{0, MODE_MAX,  0, 0, 32'h0000_0000, 0, 32'h0, 0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].cfg)
            set_config(dir_tab[i].mode, dir_tab[i].inner, dir_tab[i].axis);
         send_element(dir_tab[i].elem);
         if (dir_tab[i].chk && (pending_results.size() == 0 ||
             pending_results[$].value !== dir_tab[i].val ||
             pending_results[$].ovf !== dir_tab[i].ovf)) begin
            $display("%0t: table row %0d expected %h/%b, model gives another value",
                     $time, i, dir_tab[i].val, dir_tab[i].ovf);
            errors++;
         end
      end

      // random phases
      phase = 0;
      while (elems_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 3) == 0) calm = ~calm;
         mode  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
         inner = $urandom_range(1, 6);
         axis  = $urandom_range(1, 6);
         if ($urandom_range(0, 4) == 0) inner = $urandom_range(1, 40);
         if ($urandom_range(0, 4) == 0) axis  = $urandom_range(1, 40);
         case (phase % 23)
            7: begin   // widest row, clamped from an oversize value
               inner = 2047;
               axis  = 1;
            end
            15: begin  // deepest axis, clamped from an oversize value
               inner = 1;
               axis  = 32'h1_ffff;
            end
            default: ;
         endcase
         set_config(mode, inner, axis);
         if (cur_inner * cur_axis > 200) begin
            count = $urandom_range(20, 40);   // partial group only
         end else begin
            count = $urandom_range(1, 3) * cur_inner * cur_axis;
            if ($urandom_range(0, 3) == 0)
               count += $urandom_range(0, cur_inner * cur_axis - 1);
         end
         // stop close to the item goal
         if (count > ITEM_GOAL - elems_sent) count = ITEM_GOAL - elems_sent;
         repeat (count) send_element(rand_elem());
         phase++;
      end

      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/iar_pkg.sv
rtl/iar_ram.sv
rtl/iar_ctrl.sv
rtl/iar_dp.sv
rtl/int_axis_reduce_unit.sv
bench/tb.sv
